### hdl/arpc_pkg.sv
// arpc_pkg: request/response payload types, the per-cell search token and
// the shared constants of the ARP address cache. No dependencies.
`timescale 1ns / 1ps

package arpc_pkg;

  localparam int IP_W  = 32;
  localparam int MAC_W = 48;

  localparam logic [7:0] ALL_ONES_BYTE   = 8'hff;
  localparam logic [7:0] HW_LEN_REQUIRED = 8'd6;
  localparam logic [7:0] PR_LEN_REQUIRED = 8'd4;

  localparam logic [IP_W-1:0]  BCAST_IP  = {4{ALL_ONES_BYTE}};
  localparam logic [MAC_W-1:0] BCAST_MAC = {6{ALL_ONES_BYTE}};

  // command codes
  localparam logic CMD_PACKET = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXP_HW_TYPE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXP_PR_TYPE = 2'd2;

  localparam logic [15:0] RST_EXP_HW_TYPE = 16'h0001;
  localparam logic [15:0] RST_EXP_PR_TYPE = 16'h0800;

  typedef struct packed {
    logic              command;
    logic [15:0]       hw_type;
    logic [15:0]       proto_type;
    logic [7:0]        hw_addr_len;
    logic [7:0]        proto_addr_len;
    logic [MAC_W-1:0]  sender_mac;
    logic [IP_W-1:0]   sender_ip;
    logic [IP_W-1:0]   target_ip;
    logic [IP_W-1:0]   lookup_ip;
  } arp_req_t;

  typedef struct packed {
    logic              accepted;
    logic              hit;
    logic              added;
    logic              add_dropped;
    logic [MAC_W-1:0]  lookup_mac;
  } arp_rsp_t;

  // Token that walks the cell chain, one cell per cycle.
  typedef struct packed {
    logic              lookup;    // lookup command, never changes state
    logic              accepted;  // header checks passed (always set for lookup)
    logic              add_want;  // add pair if no cell matches
    logic              found;     // an earlier cell matched
    logic              added;     // an earlier cell took the pair
    logic [IP_W-1:0]   key;       // sender ip or lookup ip
    logic [MAC_W-1:0]  mac;       // sender mac, or lookup result
  } tok_t;

endpackage

### hdl/arpc_cell.sv
// arpc_cell: one table entry plus one stage of the search token pipeline.
// Depends on arpc_pkg.
`timescale 1ns / 1ps

module arpc_cell #(
  parameter bit RESET_ENTRY = 1'b0
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                tok_vld_in,
  input  arpc_pkg::tok_t      tok_in,
  output logic                tok_vld_out,
  output arpc_pkg::tok_t      tok_out
);

  logic                       valid_r;
  logic [arpc_pkg::IP_W-1:0]  ip_r;
  logic [arpc_pkg::MAC_W-1:0] mac_r;
  logic                       tok_vld_r;
  arpc_pkg::tok_t             tok_r, tok_nxt;
  logic                       match, claim, upd;

  assign match = tok_vld_in && tok_in.accepted && !tok_in.found &&
                 valid_r && (tok_in.key == ip_r);
  assign upd   = match && !tok_in.lookup;
  // Valid entries form a prefix, so the first free cell seen is the lowest
  // one and no later cell can still match.
  assign claim = tok_vld_in && tok_in.add_want && !tok_in.found &&
                 !tok_in.added && !valid_r;

  always_comb begin
    tok_nxt = tok_in;
    if (match) begin
      tok_nxt.found = 1'b1;
      if (tok_in.lookup) tok_nxt.mac = mac_r;
    end
    if (claim) tok_nxt.added = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= RESET_ENTRY;
    end else if (claim) begin
      valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n && RESET_ENTRY) begin
      ip_r  <= arpc_pkg::BCAST_IP;
      mac_r <= arpc_pkg::BCAST_MAC;
    end else if (claim) begin
      ip_r  <= tok_in.key;
      mac_r <= tok_in.mac;
    end else if (upd) begin
      mac_r <= tok_in.mac;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_vld_r <= 1'b0;
    end else begin
      tok_vld_r <= tok_vld_in;
    end
  end

  always_ff @(posedge clk) begin
    tok_r <= tok_nxt;
  end

  assign tok_vld_out = tok_vld_r;
  assign tok_out     = tok_r;

endmodule

### hdl/arpc_result.sv
// arpc_result: turns the token leaving the last cell into a response and
// holds it in an output register with one skid slot. Depends on arpc_pkg.
`timescale 1ns / 1ps

module arpc_result (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                exit_vld,
  input  arpc_pkg::tok_t      exit_tok,
  input  logic                out_stall,
  output logic                out_valid,
  output arpc_pkg::arp_rsp_t  out_data,
  output logic                skid_busy
);

  arpc_pkg::arp_rsp_t rsp;
  arpc_pkg::arp_rsp_t out_r, skid_r;
  logic               out_valid_r, skid_valid_r;
  logic               pop;

  always_comb begin
    rsp.accepted    = exit_tok.accepted;
    rsp.hit         = exit_tok.found;
    rsp.added       = exit_tok.added;
    rsp.add_dropped = exit_tok.add_want && !exit_tok.found && !exit_tok.added;
    rsp.lookup_mac  = exit_tok.lookup ? exit_tok.mac : '0;
  end

  assign pop = out_valid_r && !out_stall;

  // The skid slot only fills while nothing else is in the chain.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) skid_valid_r <= 1'b0;
    end else if (exit_vld) begin
      if (!out_valid_r || pop) out_valid_r <= 1'b1;
      else skid_valid_r <= 1'b1;
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) out_r <= skid_r;
    end else if (exit_vld) begin
      if (!out_valid_r || pop) out_r <= rsp;
      else skid_r <= rsp;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign skid_busy = skid_valid_r;

endmodule

### hdl/arp_address_cache.sv
// arp_address_cache: IPv4-to-MAC cache built as a chain of entry cells.
// Depends on arpc_pkg, arpc_cell and arpc_result.
//
//  channel | direction | handshake           | payload
//  in_     | input     | in_valid / in_stall | arpc_pkg::arp_req_t
//  out_    | output    | out_valid/out_stall | arpc_pkg::arp_rsp_t
//  cfg_    | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// out_valid rises once a request has passed the header-check register (loaded
// at the accepting edge), each cell in turn and then the output register.
// One request is in the chain at a time; in_stall is high until it leaves the
// last cell and while the skid slot holds a response.
// Reset: entry 0 holds the broadcast pair, all other entries are free,
// registers take their default values. cfg_ready is always high.
`timescale 1ns / 1ps

module arp_address_cache #(
  parameter int TABLE_DEPTH = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  arpc_pkg::arp_req_t                in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output arpc_pkg::arp_rsp_t                out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [arpc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [31:0]                       cfg_data
);

  logic [arpc_pkg::IP_W-1:0] own_ip_r;
  logic [15:0]               exp_hw_type_r;
  logic [15:0]               exp_pr_type_r;

  logic                      busy_r;
  logic                      skid_busy;
  logic                      in_acc;
  logic                      hdr_ok;
  arpc_pkg::tok_t            tok_new;

  logic [TABLE_DEPTH:0]      tok_vld;
  arpc_pkg::tok_t            tok [TABLE_DEPTH+1];
  arpc_pkg::tok_t            entry_tok_r;
  logic                      entry_vld_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      own_ip_r      <= '0;
      exp_hw_type_r <= arpc_pkg::RST_EXP_HW_TYPE;
      exp_pr_type_r <= arpc_pkg::RST_EXP_PR_TYPE;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        arpc_pkg::CFG_OWN_IP:      own_ip_r      <= cfg_data;
        arpc_pkg::CFG_EXP_HW_TYPE: exp_hw_type_r <= cfg_data[15:0];
        arpc_pkg::CFG_EXP_PR_TYPE: exp_pr_type_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign in_stall = busy_r || skid_busy;
  assign in_acc   = in_valid && !in_stall;

  assign hdr_ok = (in_data.hw_type == exp_hw_type_r) &&
                  (in_data.hw_addr_len == arpc_pkg::HW_LEN_REQUIRED) &&
                  (in_data.proto_type == exp_pr_type_r) &&
                  (in_data.proto_addr_len == arpc_pkg::PR_LEN_REQUIRED);

  always_comb begin
    tok_new.found = 1'b0;
    tok_new.added = 1'b0;
    if (in_data.command == arpc_pkg::CMD_LOOKUP) begin
      tok_new.lookup   = 1'b1;
      tok_new.accepted = 1'b1;
      tok_new.add_want = 1'b0;
      tok_new.key      = in_data.lookup_ip;
      tok_new.mac      = '0;
    end else begin
      tok_new.lookup   = 1'b0;
      tok_new.accepted = hdr_ok;
      tok_new.add_want = hdr_ok && (in_data.target_ip == own_ip_r);
      tok_new.key      = in_data.sender_ip;
      tok_new.mac      = in_data.sender_mac;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_vld_r <= 1'b0;
    end else begin
      entry_vld_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) entry_tok_r <= tok_new;
  end

  assign tok_vld[0] = entry_vld_r;
  assign tok[0]     = entry_tok_r;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    arpc_cell #(
      .RESET_ENTRY (i == 0)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .tok_vld_in  (tok_vld[i]),
      .tok_in      (tok[i]),
      .tok_vld_out (tok_vld[i+1]),
      .tok_out     (tok[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (in_acc) begin
      busy_r <= 1'b1;
    end else if (tok_vld[TABLE_DEPTH]) begin
      busy_r <= 1'b0;
    end
  end

  arpc_result u_result (
    .clk       (clk),
    .rst_n     (rst_n),
    .exit_vld  (tok_vld[TABLE_DEPTH]),
    .exit_tok  (tok[TABLE_DEPTH]),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .skid_busy (skid_busy)
  );

`ifndef SYNTH
  a_one_in_chain: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(tok_vld) <= 1)
    else $error("more than one request in the cell chain");

  a_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> busy_r)
    else $error("accepted request did not mark the chain busy");

  a_exit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    tok_vld[TABLE_DEPTH] |-> busy_r)
    else $error("request left the chain while not busy");
`endif

endmodule
